// ----- design/nsr_pkg.sv -----
`timescale 1ns / 1ps

package nsr_pkg;

    // Field widths
    localparam int RADICAND_W = 32;
    localparam int ROOT_W     = 48;
    localparam int ITER_W     = 7;
    localparam int STATUS_W   = 2;
    localparam int TOL_W      = 32;

    // Stream word widths (byte padded)
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 64;

    // Tolerance register is Q16.16
    localparam int TOL_FRAC   = 16;
    // Aligned tolerance, wide enough for the largest fraction width
    localparam int TOLA_W     = 56;

    // Datapath widths
    localparam int HALF_W     = ROOT_W / 2;
    localparam int PROD_W     = 2 * HALF_W;
    localparam int ACC_W      = 2 * ROOT_W + 1;
    localparam int DIV_W      = ROOT_W + 1;
    localparam int DCNT_W     = $clog2(ROOT_W);

    // Saturated estimate
    localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_CONVERGED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_CAP       = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ZERO      = 2'd2;

    // Datapath operations
    typedef enum logic [3:0] {
        DP_NOP    = 4'd0,
        DP_LOAD   = 4'd1,
        DP_MUL0   = 4'd2,
        DP_MUL1   = 4'd3,
        DP_MUL2   = 4'd4,
        DP_MUL3   = 4'd5,
        DP_DIVCHK = 4'd6,
        DP_DIV    = 4'd7,
        DP_UPDATE = 4'd8
    } dp_op_t;

    // Controller to datapath
    typedef struct packed {
        dp_op_t op;
        logic   emit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic guess_zero;
        logic skip_div;
        logic div_last;
        logic stop;
    } dp_sts_t;

endpackage

// ----- design/nsr_dp.sv -----
`timescale 1ns / 1ps

module nsr_dp #(
    parameter int MAX_ITERATIONS = 32,
    parameter int FRACTION_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [nsr_pkg::TOL_W-1:0]       cfg_wr_data,
    input  logic [nsr_pkg::S_TDATA_W-1:0]   in_data,
    input  nsr_pkg::dp_cmd_t                cmd,
    output nsr_pkg::dp_sts_t                sts,
    output logic [nsr_pkg::M_TDATA_W-1:0]   out_data
);

    localparam int PAD_W = nsr_pkg::M_TDATA_W - nsr_pkg::ROOT_W - nsr_pkg::ITER_W
                           - nsr_pkg::STATUS_W;

    logic [nsr_pkg::TOL_W-1:0]      tol_reg;
    logic [nsr_pkg::RADICAND_W-1:0] n_reg;
    logic [nsr_pkg::ROOT_W-1:0]     x_reg;
    logic [nsr_pkg::ROOT_W-1:0]     quo_reg;
    logic [nsr_pkg::PROD_W-1:0]     prod_reg;
    logic [nsr_pkg::ACC_W-1:0]      acc_reg;
    logic [nsr_pkg::DIV_W-1:0]      rem_reg;
    logic [nsr_pkg::DCNT_W-1:0]     div_cnt_reg;
    logic [nsr_pkg::ITER_W-1:0]     iter_reg;
    logic [nsr_pkg::STATUS_W-1:0]   stat_reg;
    logic [nsr_pkg::ROOT_W-1:0]     out_root_reg;
    logic [nsr_pkg::ITER_W-1:0]     out_iter_reg;
    logic [nsr_pkg::STATUS_W-1:0]   out_stat_reg;

    logic [nsr_pkg::RADICAND_W-1:0] radicand_in;
    logic [nsr_pkg::ROOT_W-1:0]     guess_in;
    logic [nsr_pkg::HALF_W-1:0]     mul_a;
    logic [nsr_pkg::HALF_W-1:0]     mul_b;
    logic [nsr_pkg::PROD_W-1:0]     prod;
    logic [nsr_pkg::ACC_W-1:0]      n_shift;
    logic [nsr_pkg::DIV_W-1:0]      div_d;
    logic [nsr_pkg::DIV_W-1:0]      acc_hi;
    logic [nsr_pkg::DIV_W:0]        rem_sh;
    logic [nsr_pkg::DIV_W:0]        rem_sub;
    logic                           rem_ge;
    logic                           x_zero;
    logic                           sat;
    logic [nsr_pkg::ROOT_W-1:0]     diff;
    logic [nsr_pkg::TOLA_W-1:0]     tol_al;
    logic                           conv;
    logic [nsr_pkg::ITER_W-1:0]     iter_inc;
    logic                           cap;

    // Unpack the request
    assign radicand_in = in_data[nsr_pkg::RADICAND_W-1:0];
    assign guess_in    = in_data[nsr_pkg::RADICAND_W +: nsr_pkg::ROOT_W];

    // Align the tolerance to the estimate's fraction width
    generate
        if (FRACTION_BITS >= nsr_pkg::TOL_FRAC) begin : g_tol_up
            assign tol_al = nsr_pkg::TOLA_W'(tol_reg) << (FRACTION_BITS - nsr_pkg::TOL_FRAC);
        end else begin : g_tol_down
            assign tol_al = nsr_pkg::TOLA_W'(tol_reg >> (nsr_pkg::TOL_FRAC - FRACTION_BITS));
        end
    endgenerate

    // Select half-word operands for the shared multiplier
    always_comb
    begin
        mul_a = x_reg[nsr_pkg::HALF_W-1:0];
        mul_b = x_reg[nsr_pkg::HALF_W-1:0];
        if (cmd.op == nsr_pkg::DP_MUL1)
        begin
            mul_b = x_reg[nsr_pkg::ROOT_W-1:nsr_pkg::HALF_W];
        end
        else if (cmd.op == nsr_pkg::DP_MUL2)
        begin
            mul_a = x_reg[nsr_pkg::ROOT_W-1:nsr_pkg::HALF_W];
            mul_b = x_reg[nsr_pkg::ROOT_W-1:nsr_pkg::HALF_W];
        end
    end

    assign prod    = mul_a * mul_b;
    assign n_shift = nsr_pkg::ACC_W'(n_reg) << (2 * FRACTION_BITS);

    // Divisor 2x, overflow check and one restoring division step
    assign div_d   = {x_reg, 1'b0};
    assign acc_hi  = acc_reg[nsr_pkg::ACC_W-1:nsr_pkg::ROOT_W];
    assign x_zero  = (x_reg == '0);
    assign sat     = (acc_hi >= div_d);
    assign rem_sh  = {rem_reg, acc_reg[nsr_pkg::ROOT_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, div_d});
    assign rem_sub = rem_sh - {1'b0, div_d};

    // Convergence and iteration cap
    assign diff     = (quo_reg > x_reg) ? (quo_reg - x_reg) : (x_reg - quo_reg);
    assign conv     = (nsr_pkg::TOLA_W'(diff) < tol_al);
    assign iter_inc = iter_reg + nsr_pkg::ITER_W'(1);
    assign cap      = (iter_inc == nsr_pkg::ITER_W'(MAX_ITERATIONS));

    assign sts.guess_zero = (guess_in == '0);
    assign sts.skip_div   = x_zero || sat;
    assign sts.div_last   = (div_cnt_reg == '0);
    assign sts.stop       = conv || cap;

    assign out_data = {{PAD_W{1'b0}}, out_stat_reg, out_iter_reg, out_root_reg};

    // Hold the tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= nsr_pkg::TOL_W'(1);
        end
        else if (cfg_wr_en)
        begin
            tol_reg <= cfg_wr_data;
        end
    end

    // Division bit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.op == nsr_pkg::DP_DIVCHK)
        begin
            div_cnt_reg <= nsr_pkg::DCNT_W'(nsr_pkg::ROOT_W - 1);
        end
        else if (cmd.op == nsr_pkg::DP_DIV)
        begin
            div_cnt_reg <= div_cnt_reg - nsr_pkg::DCNT_W'(1);
        end
    end

    // Execute datapath operations
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            nsr_pkg::DP_LOAD:
            begin
                n_reg    <= radicand_in;
                x_reg    <= guess_in;
                iter_reg <= '0;
                stat_reg <= nsr_pkg::STAT_ZERO;
            end
            nsr_pkg::DP_MUL0:
            begin
                prod_reg <= prod;
            end
            nsr_pkg::DP_MUL1:
            begin
                acc_reg  <= nsr_pkg::ACC_W'(prod_reg) + n_shift;
                prod_reg <= prod;
            end
            nsr_pkg::DP_MUL2:
            begin
                acc_reg  <= acc_reg + (nsr_pkg::ACC_W'(prod_reg) << (nsr_pkg::HALF_W + 1));
                prod_reg <= prod;
            end
            nsr_pkg::DP_MUL3:
            begin
                acc_reg  <= acc_reg + (nsr_pkg::ACC_W'(prod_reg) << nsr_pkg::ROOT_W);
            end
            nsr_pkg::DP_DIVCHK:
            begin
                rem_reg <= acc_hi;
                if (x_zero)
                begin
                    quo_reg <= '0;
                end
                else if (sat)
                begin
                    quo_reg <= nsr_pkg::ROOT_MAX;
                end
                else
                begin
                    quo_reg <= '0;
                end
            end
            nsr_pkg::DP_DIV:
            begin
                acc_reg <= acc_reg << 1;
                quo_reg <= {quo_reg[nsr_pkg::ROOT_W-2:0], rem_ge};
                rem_reg <= rem_ge ? rem_sub[nsr_pkg::DIV_W-1:0] : rem_sh[nsr_pkg::DIV_W-1:0];
            end
            nsr_pkg::DP_UPDATE:
            begin
                x_reg    <= quo_reg;
                iter_reg <= iter_inc;
                stat_reg <= conv ? nsr_pkg::STAT_CONVERGED : nsr_pkg::STAT_CAP;
            end
            default:
            begin
            end
        endcase

        // Capture the result into the output register
        if (cmd.emit)
        begin
            out_root_reg <= x_reg;
            out_iter_reg <= iter_reg;
            out_stat_reg <= stat_reg;
        end
    end

`ifndef NO_ASSERTIONS
    // Partial remainder stays below the divisor throughout the division
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == nsr_pkg::DP_DIV) |-> (rem_reg < div_d))
        else $error("partial remainder not below divisor");
`endif

endmodule

// ----- design/nsr_ctrl.sv -----
`timescale 1ns / 1ps

module nsr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  nsr_pkg::dp_sts_t  sts,
    output nsr_pkg::dp_cmd_t  cmd
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_MUL0   = 9'b000000010,
        ST_MUL1   = 9'b000000100,
        ST_MUL2   = 9'b000001000,
        ST_MUL3   = 9'b000010000,
        ST_DIVCHK = 9'b000100000,
        ST_DIV    = 9'b001000000,
        ST_UPDATE = 9'b010000000,
        ST_FINISH = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Sequence one request through multiply, divide and update steps
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = nsr_pkg::DP_NOP;
        cmd.emit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = nsr_pkg::DP_LOAD;
                    state_next = sts.guess_zero ? ST_FINISH : ST_MUL0;
                end
            end
            ST_MUL0:
            begin
                cmd.op     = nsr_pkg::DP_MUL0;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.op     = nsr_pkg::DP_MUL1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.op     = nsr_pkg::DP_MUL2;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.op     = nsr_pkg::DP_MUL3;
                state_next = ST_DIVCHK;
            end
            ST_DIVCHK:
            begin
                cmd.op     = nsr_pkg::DP_DIVCHK;
                state_next = sts.skip_div ? ST_UPDATE : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = nsr_pkg::DP_DIV;
                if (sts.div_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.op     = nsr_pkg::DP_UPDATE;
                state_next = sts.stop ? ST_FINISH : ST_MUL0;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance state and hold the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A result is only written into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result written over an untaken one");

    // The last division bit always leads to the update step
    a_div_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && sts.div_last) |=> (state_reg == ST_UPDATE))
        else $error("division did not end in update");

    // A zero guess goes straight to the result without any step
    a_zero_guess: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && sts.guess_zero) |=> (state_reg == ST_FINISH))
        else $error("zero guess entered the iteration");
`endif

endmodule

// ----- design/newton_square_root_unit.sv -----
`timescale 1ns / 1ps

// Newton-Raphson square root in fixed point. Each request carries a 32-bit
// unsigned radicand and a 48-bit starting estimate with FRACTION_BITS
// fraction bits; the unit iterates x := (x*x + n) / (2x) until two successive
// estimates differ by less than the tolerance register (Q16.16, reset 1), or
// until MAX_ITERATIONS steps are done, and returns the last estimate
// (saturating), the step count and a status (converged, cap reached, zero
// guess). A request is taken only while no other one is in work; a finished
// result waits in the output register, so the next request may enter before
// it is taken. Each Newton step runs four steps that form x*x + n with the
// shared 24x24 multiplier, an overflow check, the bit-serial restoring
// divider (one step per quotient bit, 48 bits) and an update step; the
// divider is skipped when the quotient saturates or the estimate is zero. A
// zero guess skips the Newton steps and goes straight to the result. Write
// the tolerance only while the unit is idle.
module newton_square_root_unit #(
    parameter int MAX_ITERATIONS = 32,
    parameter int FRACTION_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [nsr_pkg::TOL_W-1:0]      cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] radicand, [79:32] initial_guess
    input  logic [nsr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [47:0] root, [54:48] iterations_used, [56:55] status, [63:57] zero
    output logic [nsr_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    nsr_pkg::dp_cmd_t cmd;
    nsr_pkg::dp_sts_t sts;

    // Controller: handshakes and step sequencing
    nsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: multiplier, divider, convergence test and result register
    nsr_dp #(
        .MAX_ITERATIONS (MAX_ITERATIONS),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_axis_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .out_data    (m_axis_tdata)
    );

endmodule
